// ===== hw/rtl/lqht_pkg.sv =====
// ----------------------------------------------------------------------------
// Link quality hop trigger package
// Item types, register indexes and state codes of the block; its checker shares
// the result type.
// ----------------------------------------------------------------------------
package lqht_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned CntW     = $clog2(DivSteps);

  typedef enum logic [CfgIdxW-1:0] {
    REG_FLOOR_DBM       = 3'd0,
    REG_HOP_THRESHOLD   = 3'd1,
    REG_RSSI_GRADE_STEP = 3'd2,
    REG_COST_LOW_MARK   = 3'd3,
    REG_COST_GRADE_STEP = 3'd4,
    REG_MAX_PENALTY     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_FOLD = 2'd2
  } state_e;

  typedef struct packed {
    logic              link_active;
    logic              link_moving;
    logic signed [7:0] rssi_level;
    logic        [7:0] link_cost;
    logic              last_link;
  } in_t;

  typedef struct packed {
    logic       hop;
    logic [7:0] window_penalty;
    logic [7:0] bad_window_total;
  } out_t;

endpackage

// ===== hw/rtl/link_quality_hop_trigger.sv =====
// ----------------------------------------------------------------------------
// Link quality hop trigger
// Grades each link of a radio window and raises a hop on the window's last
// item once the saturating bad-window count reaches the threshold.
// ----------------------------------------------------------------------------
// An item for an inactive or idle link goes from the accept to the fold state and
// back to idle. An item for a moving link first passes one 8-step restoring
// divider, one quotient bit a cycle, that grades first the RSSI shortfall and
// then the link cost. At most one result is held in the output register, and the
// block accepts a new item while it waits to be taken.
module link_quality_hop_trigger (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lqht_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lqht_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lqht_pkg::in_t               in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lqht_pkg::out_t              out_o
);
  import lqht_pkg::*;

  logic signed [7:0] floor_q;
  logic [15:0]       thresh_q;
  logic [7:0]        rstep_q, cost_low_q, cstep_q, maxp_q;

  state_e            state_q, state_d;
  in_t               item_q, item_d;
  logic              phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [7:0]        rem_q, rem_d, quo_q, quo_d;
  logic [7:0]        rp_q, rp_d;
  logic [7:0]        worst_q, worst_d, count_q, count_d;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              accept;
  logic signed [8:0] short_in;
  logic [7:0]        cost_over;
  logic              rssi_hit, cost_hit;
  logic [7:0]        divisor;
  logic [8:0]        shifted;
  logic              qbit;
  logic [7:0]        pen, worst_new;
  logic [8:0]        sum;
  logic [7:0]        sat;

  function automatic logic [7:0] graded(input logic [7:0] q, input logic [7:0] maxp);
    logic [8:0] p;
    p = {1'b0, q} + 9'd1;
    if (p > {1'b0, maxp}) begin
      return maxp;
    end
    return p[7:0];
  endfunction

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    short_in  = $signed({floor_q[7], floor_q}) - $signed({in_i.rssi_level[7], in_i.rssi_level});
    cost_over = item_q.link_cost - cost_low_q;
    rssi_hit  = (item_q.rssi_level < floor_q);
    cost_hit  = (item_q.link_cost > cost_low_q);
    if (phase_q) begin
      divisor = (cstep_q == 8'd0) ? 8'd1 : cstep_q;
    end else begin
      divisor = (rstep_q == 8'd0) ? 8'd1 : rstep_q;
    end
    shifted = {rem_q, quo_q[7]};
    qbit    = (shifted >= {1'b0, divisor});
  end

  always_comb begin
    if (!item_q.link_active) begin
      pen = 8'd0;
    end else if (!item_q.link_moving) begin
      pen = maxp_q;
    end else begin
      pen = rp_q;
      if (cost_hit && (graded(quo_q, maxp_q) > pen)) begin
        pen = graded(quo_q, maxp_q);
      end
    end
    worst_new = (pen > worst_q) ? pen : worst_q;
    sum       = {1'b0, count_q} + {1'b0, worst_new};
    sat       = sum[8] ? 8'hFF : sum[7:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_i.link_active && in_i.link_moving) ? ST_DIV : ST_FOLD;
        end
      end
      ST_DIV: begin
        if (cnt_q == CntW'(DivSteps - 1) && phase_q) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!item_q.last_link || !out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_d      = item_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    rp_d        = rp_q;
    worst_d     = worst_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d  = in_i;
          phase_d = 1'b0;
          cnt_d   = '0;
          rem_d   = '0;
          quo_d   = short_in[7:0];
        end
      end
      ST_DIV: begin
        rem_d = qbit ? 8'(shifted - {1'b0, divisor}) : shifted[7:0];
        quo_d = {quo_q[6:0], qbit};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1) && !phase_q) begin
          rp_d    = rssi_hit ? graded({quo_q[6:0], qbit}, maxp_q) : 8'd0;
          phase_d = 1'b1;
          rem_d   = '0;
          quo_d   = cost_over;
        end
      end
      ST_FOLD: begin
        if (!item_q.last_link) begin
          worst_d = worst_new;
        end else if (!out_valid_q || out_ready_i) begin
          out_d.window_penalty = worst_new;
          out_d.hop            = 1'b0;
          if (worst_new == 8'd0) begin
            count_d = 8'd0;
          end else if ({8'd0, sat} >= thresh_q) begin
            count_d   = 8'd0;
            out_d.hop = 1'b1;
          end else begin
            count_d = sat;
          end
          out_d.bad_window_total = (worst_new == 8'd0 || {8'd0, sat} >= thresh_q) ? 8'd0 : sat;
          out_valid_d = 1'b1;
          worst_d     = 8'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      worst_q     <= 8'd0;
      count_q     <= 8'd0;
      out_valid_q <= 1'b0;
      floor_q     <= -8'sd80;
      thresh_q    <= 16'd4;
      rstep_q     <= 8'd6;
      cost_low_q  <= 8'd15;
      cstep_q     <= 8'd5;
      maxp_q      <= 8'd4;
    end else begin
      state_q     <= state_d;
      worst_q     <= worst_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_FLOOR_DBM:       floor_q    <= cfg_wdata_i[7:0];
          REG_HOP_THRESHOLD:   thresh_q   <= cfg_wdata_i;
          REG_RSSI_GRADE_STEP: rstep_q    <= cfg_wdata_i[7:0];
          REG_COST_LOW_MARK:   cost_low_q <= cfg_wdata_i[7:0];
          REG_COST_GRADE_STEP: cstep_q    <= cfg_wdata_i[7:0];
          REG_MAX_PENALTY:     maxp_q     <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    phase_q <= phase_d;
    cnt_q   <= cnt_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    rp_q    <= rp_d;
    out_q   <= out_d;
  end

endmodule

// ===== hw/rtl/lqht_checker.sv =====
// ----------------------------------------------------------------------------
// Link quality hop trigger checker
// Port-level properties of the hop trigger, bound into each instance of it.
// ----------------------------------------------------------------------------
module lqht_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input lqht_pkg::out_t              out_o
);
  import lqht_pkg::*;

  // A waiting result stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // A hop always clears the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.hop |-> out_o.bad_window_total == 8'd0)
    else $error("hop without cleared count");

  // A clean window never hops and leaves the count cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.window_penalty == 8'd0 |->
      !out_o.hop && out_o.bad_window_total == 8'd0)
    else $error("clean window counted as bad");

  // The block is not ready in the cycle after it takes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken without busy cycle");

endmodule

bind link_quality_hop_trigger lqht_checker u_lqht_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_o      (out_o)
);
